### hw/rtl/oblu_pkg.sv
// shared types, constants and helpers for the order book level update unit
// depends on nothing; every rtl file imports it
`timescale 1ns / 1ps
`default_nettype none

package oblu_pkg;

  // book geometry
  localparam int LEVELS_PER_SIDE = 64;
  localparam int LVL_W           = $clog2(LEVELS_PER_SIDE);
  localparam int ENTRIES         = 2 * LEVELS_PER_SIDE;
  localparam int IDX_W           = LVL_W + 1;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  // price grid, units of 0.0001
  localparam logic [31:0] BASE_PRICE = 32'd1000000;
  localparam logic [31:0] TICK_STEP  = 32'd100;
  localparam logic [30:0] COUNT_MAX  = 31'h7fff_ffff;

  // message operations
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_MODIFY = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // back end sequencer
  typedef enum logic {
    BK_IDLE,
    BK_CALC
  } back_state_t;

  // incoming message
  typedef struct packed {
    logic [1:0]         mode;
    logic               is_bid;
    logic [5:0]         level_index;
    logic signed [31:0] qty_delta;
    logic [31:0]        new_price;
  } msg_t;

  // outgoing result
  typedef struct packed {
    logic [31:0] level_price;
    logic [30:0] level_size;
    logic [30:0] level_orders;
    logic [31:0] level_touches;
    logic [63:0] sequence_number;
  } res_t;

  // classified command handed from front to back
  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] delta;
    logic [31:0]        price;
    logic [31:0]        init_price;
  } cmd_t;

  // one stored price level
  typedef struct packed {
    logic [31:0] price;
    logic [30:0] size;
    logic [30:0] orders;
    logic [31:0] touches;
  } level_t;

  // queue status seen by both ends
  typedef struct packed {
    logic has_data;
    logic full;
  } q_status_t;

  // price a level holds after reset
  function automatic logic [31:0] reset_price(input logic is_bid,
                                              input logic [LVL_W-1:0] lvl);
    logic [31:0] off;
    off = 32'(lvl) * TICK_STEP;
    return is_bid ? (BASE_PRICE - off) : (BASE_PRICE + off);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/oblu_front.sv
// front end: accepts messages, decodes the operation and the table entry
// depends on oblu_pkg
`timescale 1ns / 1ps
`default_nettype none

module oblu_front import oblu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      msg_valid,
  output      logic      msg_stall,
  input  wire msg_t      msg,
  input  wire q_status_t q_status,
  output      logic      push,
  output      cmd_t      push_cmd
);

  logic fr_valid;
  cmd_t fr_cmd;
  cmd_t fr_cmd_next;
  logic lvl_take;
  logic [LVL_W-1:0] lvl;

  // handshake: hold a decoded transaction until the queue has room
  assign push      = fr_valid && !q_status.full;
  assign msg_stall = fr_valid && q_status.full;
  assign lvl_take  = msg_valid && !msg_stall;
  assign push_cmd  = fr_cmd;

  // decode operation, entry index (bid levels first) and reset price
  assign lvl = msg.level_index[LVL_W-1:0];
  always_comb begin
    fr_cmd_next            = '0;
    fr_cmd_next.op         = op_t'(msg.mode);
    fr_cmd_next.idx        = {~msg.is_bid, lvl};
    fr_cmd_next.delta      = msg.qty_delta;
    fr_cmd_next.price      = msg.new_price;
    fr_cmd_next.init_price = reset_price(msg.is_bid, lvl);
  end

  // decoded stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (lvl_take) begin
      fr_valid <= 1'b1;
    end else if (push) begin
      fr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_take) begin
      fr_cmd <= fr_cmd_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/oblu_queue.sv
// two-entry command queue between front and back end
// depends on oblu_pkg
`timescale 1ns / 1ps
`default_nettype none

module oblu_queue import oblu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire cmd_t      push_cmd,
  input  wire logic      pop,
  output      cmd_t      head,
  output      q_status_t q_status
);

  cmd_t slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head              = slots[rd_ptr];
  assign q_status.has_data = (count != '0);
  assign q_status.full     = (count == QCNT_W'(QUEUE_DEPTH));

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/oblu_back.sv
// back end: read-modify-write of the level table, sequence count, result register
// depends on oblu_pkg
`timescale 1ns / 1ps
`default_nettype none

module oblu_back import oblu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire q_status_t q_status,
  input  wire cmd_t      head,
  output      logic      pop,
  output      logic      res_valid,
  input  wire logic      res_stall,
  output      res_t      res
);

  level_t mem [ENTRIES];
  logic [ENTRIES-1:0] written;

  back_state_t state;
  back_state_t state_next;

  cmd_t   cmd;
  level_t rd_level;
  logic   rd_written;
  logic [63:0] seq;
  logic [63:0] seq_next;

  level_t cur;
  level_t upd;
  logic signed [33:0] size_ext;
  logic signed [33:0] delta_ext;
  logic signed [33:0] size_sum;
  logic [30:0] size_sat;
  logic calc;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (pop) state_next = BK_CALC;
      BK_CALC: state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // outputs: take a command only when the result slot is free next cycle
  always_comb begin
    pop  = 1'b0;
    calc = 1'b0;
    unique case (state)
      BK_IDLE: pop  = q_status.has_data && (!res_valid || !res_stall);
      BK_CALC: calc = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // read port and command latch
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd        <= head;
      rd_level   <= mem[head.idx];
      rd_written <= written[head.idx];
    end
  end

  // entries never written read as their reset contents
  always_comb begin
    if (rd_written) begin
      cur = rd_level;
    end else begin
      cur.price   = cmd.init_price;
      cur.size    = '0;
      cur.orders  = '0;
      cur.touches = '0;
    end
  end

  // size update with clamp to zero and saturation
  assign size_ext  = {3'b000, cur.size};
  assign delta_ext = {{2{cmd.delta[31]}}, cmd.delta};
  assign size_sum  = (cmd.op == OP_CANCEL) ? (size_ext - delta_ext) : (size_ext + delta_ext);

  always_comb begin
    priority if (size_sum[33]) begin
      size_sat = '0;
    end else if (size_sum[32:31] != 2'b00) begin
      size_sat = COUNT_MAX;
    end else begin
      size_sat = size_sum[30:0];
    end
  end

  // new level contents
  always_comb begin
    upd         = cur;
    upd.touches = cur.touches + 32'd1;
    unique case (cmd.op)
      OP_ADD: begin
        upd.price = cmd.price;
        upd.size  = size_sat;
        if (cur.orders != COUNT_MAX) upd.orders = cur.orders + 31'd1;
      end
      OP_CANCEL: begin
        upd.size = size_sat;
        if (cur.orders != '0) upd.orders = cur.orders - 31'd1;
      end
      OP_MODIFY: begin
        upd.price = cmd.price;
        upd.size  = size_sat;
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  assign seq_next = seq + 64'd1;

  // write port
  always_ff @(posedge clk) begin
    if (calc) begin
      mem[cmd.idx] <= upd;
    end
  end

  // written flags and sequence count
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      seq     <= '0;
    end else if (calc) begin
      written[cmd.idx] <= 1'b1;
      seq              <= seq_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (calc) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc) begin
      res.level_price     <= upd.price;
      res.level_size      <= upd.size;
      res.level_orders    <= upd.orders;
      res.level_touches   <= upd.touches;
      res.sequence_number <= seq_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/order_book_level_update_unit.sv
// Order book level update unit: bid and ask tables of 64 price levels each.
// Each message passes through the back end as a read of the level from the
// 128-entry level memory (registered read) followed by an update, a write
// back and a load of the result register; the back end takes no new message
// until it is through with the last. The front end and a two-entry queue
// keep taking messages while the back end works or while a result waits to
// be taken. When nothing stalls, a message moves through the front-end
// register, a queue slot, the read latch and the result register. Levels
// start at reset prices with zero size, orders and touches; no clearing pass.
// depends on oblu_pkg, oblu_front, oblu_queue, oblu_back
`timescale 1ns / 1ps
`default_nettype none

module order_book_level_update_unit import oblu_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic msg_valid,
  output      logic msg_stall,
  input  wire msg_t msg,
  output      logic res_valid,
  input  wire logic res_stall,
  output      res_t res
);

  q_status_t q_status;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;

  // accept and classify
  oblu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decoupling queue
  oblu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // level update and result
  oblu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // a popped command yields a result through the read latch and the result register
  assert property (@(posedge clk) disable iff (rst) pop |-> ##2 res_valid)
    else $error("popped command produced no result");

  // read-modify-write never overlaps
  assert property (@(posedge clk) disable iff (rst) pop |=> !pop)
    else $error("back end popped on consecutive cycles");

  // a new result always comes from a popped command
  assert property (@(posedge clk) disable iff (rst) $rose(res_valid) |-> $past(pop, 2))
    else $error("result appeared without a command");

  // the queue is never popped empty
  assert property (@(posedge clk) disable iff (rst) pop |-> q_status.has_data)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

### verif/order_book_level_update_unit_tb.sv
// self-checking testbench for the order book level update unit
// depends on oblu_pkg and the order_book_level_update_unit rtl
`timescale 1ns / 1ps

module order_book_level_update_unit_tb import oblu_pkg::*; ();

  localparam int HOLD_CYCLES  = 60;
  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP    = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic msg_valid = 1'b0;
  logic msg_stall;
  msg_t msg = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  order_book_level_update_unit dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // mirror of the book: bid levels first, then ask levels
  logic [31:0] lvl_price   [ENTRIES];
  logic [30:0] lvl_size    [ENTRIES];
  logic [30:0] lvl_orders  [ENTRIES];
  logic [31:0] lvl_touches [ENTRIES];
  logic [63:0] msg_seq;

  msg_t pending_msgs [$];
  res_t expected_levels [$];

  int tx_idle_max = 0;
  int rx_idle_max = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  bit hold_request = 1'b0;
  int hold_count = 0;
  int error_count = 0;
  int msgs_sent = 0;
  int results_checked = 0;
  int saturated_count = 0;
  int clamped_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // apply one message to the mirror and return the level it leaves behind
  function automatic res_t update_level(input msg_t m);
    int idx;
    longint exact;
    longint cur;
    longint delta;
    res_t r;
    idx = int'(m.level_index) % LEVELS_PER_SIDE;
    if (!m.is_bid) idx = idx + LEVELS_PER_SIDE;
    cur = longint'(lvl_size[idx]);
    delta = longint'($signed(m.qty_delta));
    exact = cur;
    case (op_t'(m.mode))
      OP_ADD: begin
        lvl_price[idx] = m.new_price;
        exact = cur + delta;
        if (lvl_orders[idx] != COUNT_MAX) lvl_orders[idx] = lvl_orders[idx] + 31'd1;
      end
      OP_CANCEL: begin
        exact = cur - delta;
        if (lvl_orders[idx] != '0) lvl_orders[idx] = lvl_orders[idx] - 31'd1;
      end
      OP_MODIFY: begin
        lvl_price[idx] = m.new_price;
        exact = cur + delta;
      end
      default: ;
    endcase
    // size is held inside 0 .. 2^31-1 in every mode
    if (exact < 0) begin
      lvl_size[idx] = '0;
      clamped_count++;
    end else if (exact > longint'(COUNT_MAX)) begin
      lvl_size[idx] = COUNT_MAX;
      saturated_count++;
    end else begin
      lvl_size[idx] = exact[30:0];
    end
    lvl_touches[idx] = lvl_touches[idx] + 32'd1;
    msg_seq = msg_seq + 64'd1;
    r.level_price     = lvl_price[idx];
    r.level_size      = lvl_size[idx];
    r.level_orders    = lvl_orders[idx];
    r.level_touches   = lvl_touches[idx];
    r.sequence_number = msg_seq;
    return r;
  endfunction

  // random message biased toward a few hot levels so sizes pile up
  function automatic msg_t random_message();
    msg_t m;
    int unsigned hot;
    logic signed [31:0] d;
    m.mode = ($urandom_range(0, 15) == 0) ? OP_NONE : 2'($urandom_range(OP_ADD, OP_MODIFY));
    m.is_bid = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      hot = $urandom_range(0, 7);
      m.level_index = 6'((hot < 4) ? hot : hot + 56);
    end else begin
      m.level_index = 6'($urandom_range(0, LEVELS_PER_SIDE - 1));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: d = 32'(int'($urandom_range(0, 2000)) - 1000);
      4, 5, 6:    d = 32'($urandom);
      7, 8: begin
        d = 32'($urandom_range(32'h4000_0000, 32'h7fff_ffff));
        if ($urandom_range(0, 1)) d = -d;
      end
      default:    d = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
    m.qty_delta = d;
    m.new_price = $urandom_range(0, 1) ? 32'($urandom) : BASE_PRICE + 32'($urandom_range(0, 9999));
    return m;
  endfunction

  task automatic queue_msg(input op_t op, input bit bid, input int unsigned lvl,
                           input logic signed [31:0] delta, input logic [31:0] price);
    msg_t m;
    m.mode        = op;
    m.is_bid      = bid;
    m.level_index = 6'(lvl);
    m.qty_delta   = delta;
    m.new_price   = price;
    pending_msgs = {pending_msgs, m};
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %h expected %h (result %0d)",
               $realtime, what, got, want, results_checked);
    error_count++;
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_levels.size() == 0) begin
      report_mismatch("result with no message pending", 64'(got.sequence_number), '0);
      return;
    end
    want = expected_levels.pop_front();
    if (got.level_price !== want.level_price)
      report_mismatch("level_price", 64'(got.level_price), 64'(want.level_price));
    if (got.level_size !== want.level_size)
      report_mismatch("level_size", 64'(got.level_size), 64'(want.level_size));
    if (got.level_orders !== want.level_orders)
      report_mismatch("level_orders", 64'(got.level_orders), 64'(want.level_orders));
    if (got.level_touches !== want.level_touches)
      report_mismatch("level_touches", 64'(got.level_touches), 64'(want.level_touches));
    if (got.sequence_number !== want.sequence_number)
      report_mismatch("sequence_number", got.sequence_number, want.sequence_number);
    results_checked++;
  endtask

  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    @(negedge clk);
    while (pending_msgs.size() != 0 || msg_valid || expected_levels.size() != 0)
      @(negedge clk);
  endtask

  // message driver: one transaction per accepted edge, random gap after each
  always @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
      msg <= '0;
      tx_wait = 0;
    end else begin
      if (msg_valid && !msg_stall) begin
        expected_levels = {expected_levels, update_level(msg)};
        msgs_sent++;
        tx_wait = $urandom_range(0, tx_idle_max);
      end
      if (!msg_valid || !msg_stall) begin
        if (tx_wait > 0) begin
          tx_wait--;
          msg_valid <= 1'b0;
        end else if (pending_msgs.size() != 0) begin
          msg <= pending_msgs.pop_front();
          msg_valid <= 1'b1;
        end else begin
          msg_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: checks each transaction, stalls at random and on hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_valid && !res_stall) begin
        check_result(res);
        rx_wait = $urandom_range(0, rx_idle_max);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      if (hold_request) begin
        if (hold_count == HOLD_CYCLES) begin
          hold_request = 1'b0;
          hold_count = 0;
        end else begin
          hold_count++;
        end
      end
      res_stall <= hold_request || (rx_wait > 0);
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (!rst);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((msg_valid && !msg_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("order_book_level_update_unit test failed");
    $finish;
  end

  initial begin : main
    int i;
    // book after reset
    for (i = 0; i < LEVELS_PER_SIDE; i++) begin
      lvl_price[i]                   = BASE_PRICE - TICK_STEP * 32'(i);
      lvl_price[LEVELS_PER_SIDE + i] = BASE_PRICE + TICK_STEP * 32'(i);
    end
    for (i = 0; i < ENTRIES; i++) begin
      lvl_size[i]    = '0;
      lvl_orders[i]  = '0;
      lvl_touches[i] = '0;
    end
    msg_seq = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: edge levels, both sides, all operations, clamp and saturation
    tx_idle_max = 5;
    rx_idle_max = 5;
    queue_msg(OP_ADD,    1'b1, 0,  32'sd100,         32'h0000_0000);
    queue_msg(OP_ADD,    1'b0, 63, 32'sh7fff_ffff,   32'hffff_ffff);
    queue_msg(OP_ADD,    1'b0, 63, 32'sd1,           32'h0000_0001);
    queue_msg(OP_MODIFY, 1'b0, 63, 32'sh8000_0000,   32'h1234_5678);
    queue_msg(OP_CANCEL, 1'b1, 0,  32'sd50,          32'h0000_0000);
    queue_msg(OP_CANCEL, 1'b1, 0,  32'sd50,          32'hffff_ffff);
    queue_msg(OP_CANCEL, 1'b1, 0,  32'sd50,          32'h0000_0000);
    queue_msg(OP_CANCEL, 1'b1, 0,  32'sh8000_0000,   32'h0000_0000);
    queue_msg(OP_CANCEL, 1'b1, 0,  32'sh7fff_ffff,   32'h0000_0000);
    queue_msg(OP_NONE,   1'b1, 5,  32'sd1234,        32'haaaa_5555);
    queue_msg(OP_NONE,   1'b0, 42, -32'sd1,          32'h5555_5555);
    queue_msg(OP_MODIFY, 1'b1, 10, -32'sd5,          32'h8000_0000);
    queue_msg(OP_ADD,    1'b1, 63, -32'sd1,          32'h7fff_ffff);
    queue_msg(OP_ADD,    1'b0, 0,  32'sd0,           32'h0000_0000);
    queue_msg(OP_MODIFY, 1'b0, 1,  32'sh7fff_ffff,   32'hffff_ffff);
    queue_msg(OP_MODIFY, 1'b0, 1,  32'sh7fff_ffff,   32'h0000_0000);
    queue_msg(OP_CANCEL, 1'b0, 1,  32'sd1,           32'h0000_0000);
    queue_msg(OP_ADD,    1'b1, 32, 32'sd3,           BASE_PRICE);
    queue_msg(OP_ADD,    1'b1, 32, 32'sd4,           BASE_PRICE);
    queue_msg(OP_CANCEL, 1'b1, 32, 32'sd10,          BASE_PRICE);
    queue_msg(OP_NONE,   1'b1, 32, 32'sh8000_0000,   32'h0000_0000);
    wait_drained();

    // back to back on both sides
    tx_idle_max = 0;
    rx_idle_max = 0;
    repeat (500) pending_msgs = {pending_msgs, random_message()};
    wait_drained();

    // long receiver hold-off while the sender keeps offering
    hold_request = 1'b1;
    repeat (150) pending_msgs = {pending_msgs, random_message()};
    wait_drained();

    // random gaps on both sides
    tx_idle_max = 5;
    rx_idle_max = 5;
    repeat (500) pending_msgs = {pending_msgs, random_message()};
    wait_drained();

    // receiver back pressure against a full-rate sender
    tx_idle_max = 0;
    rx_idle_max = 5;
    repeat (450) pending_msgs = {pending_msgs, random_message()};
    wait_drained();

    // slow sender against a ready receiver
    tx_idle_max = 5;
    rx_idle_max = 0;
    repeat (450) pending_msgs = {pending_msgs, random_message()};
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_levels.size() != 0)
      report_mismatch("results never delivered", 64'(expected_levels.size()), '0);

    $display("checked %0d results from %0d messages over idle, back-to-back, hold-off",
             results_checked, msgs_sent);
    $display("and back-pressure phases; %0d sizes saturated, %0d clamped at zero, %0d errors",
             saturated_count, clamped_count, error_count);
    if (error_count == 0) begin
      $display("order_book_level_update_unit test passed");
    end else begin
      $display("order_book_level_update_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/oblu_pkg.sv
hw/rtl/oblu_front.sv
hw/rtl/oblu_queue.sv
hw/rtl/oblu_back.sv
hw/rtl/order_book_level_update_unit.sv
verif/order_book_level_update_unit_tb.sv
